### design/tkaq_pkg.sv
// Shared widths, limits and types of the tick alarm queue.
`default_nettype none
package tkaq_pkg;

  localparam int SLOT_W          = 4;
  localparam int TICK_W          = 32;
  localparam int DEF_NUM_ALARMS  = 16;
  localparam int MAX_OUT         = 16;

  typedef enum logic {
    REQ_TICK = 1'b0,  // one timer tick
    REQ_SET  = 1'b1   // set or cancel an alarm
  } req_kind_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] deadline;
  } entry_t;

  typedef struct packed {
    logic shift;   // take the right neighbour's entry
    logic insert;  // sorted insert of the broadcast entry
  } cell_ctl_t;

  localparam entry_t ENTRY_NONE = '{valid: 1'b0, slot: '0, deadline: '0};

endpackage
`default_nettype wire

### design/tkaq_if.sv
// Request and result channel interfaces of the tick alarm queue.
`default_nettype none
interface tkaq_req_if;
  import tkaq_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SLOT_W-1:0] alarm_slot;
  logic [TICK_W-1:0] delay_ticks;
  modport source (output valid, req_type, alarm_slot, delay_ticks, input ready);
  modport sink   (input valid, req_type, alarm_slot, delay_ticks, output ready);
endinterface

interface tkaq_res_if;
  import tkaq_pkg::*;
  logic              valid;
  logic              ready;
  logic              fired;
  logic [SLOT_W-1:0] fired_slot;
  logic [TICK_W-1:0] now_tick;
  logic              last;
  modport source (output valid, fired, fired_slot, now_tick, last, input ready);
  modport sink   (input valid, fired, fired_slot, now_tick, last, output ready);
endinterface
`default_nettype wire

### design/tick_alarm_queue_unit.sv
// Tick alarm queue: tick counter with a deadline-sorted chain of alarm cells.
// Set item: cancel done on accept; insert and registered ack follow in ST_ACK once res is free.
// Tick item: counted on accept, then one result per cycle from the chain head while res is
// free: one per fired alarm (at most 16) or a plain ack; one item is in work at a time.
// Synchronous reset clears the tick counter, the cell valid bits and the result valid bit.
`default_nettype none
module tick_alarm_queue_unit #(
  parameter int NUM_ALARMS = tkaq_pkg::DEF_NUM_ALARMS
) (
  input  wire        clk,
  input  wire        rst,
  tkaq_req_if.sink   req,
  tkaq_res_if.source res
);
  import tkaq_pkg::*;

  localparam int CNT_W = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACK  = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [TICK_W-1:0] tick_count;
  logic [CNT_W-1:0]  pop_cnt;
  logic              pend_ins;
  entry_t            ins_ent;

  logic              out_valid;
  logic              out_fired;
  logic [SLOT_W-1:0] out_slot;
  logic [TICK_W-1:0] out_tick;
  logic              out_last;

  entry_t            ent      [NUM_ALARMS];
  entry_t            right_of [NUM_ALARMS];
  entry_t            left_of  [NUM_ALARMS];
  logic [NUM_ALARMS-1:0] gt;
  logic [NUM_ALARMS-1:0] match;
  logic [NUM_ALARMS-1:0] drop_mask;
  logic [NUM_ALARMS-1:0] left_gt;
  cell_ctl_t         ctl [NUM_ALARMS];

  logic accept, is_set, slot_ok, drop_now, pop_now, emit, out_free;
  logic head_due, next_due, pop_last, ins_now;

  assign accept   = req.valid && req.ready;
  assign is_set   = (req.req_type == REQ_SET);
  assign slot_ok  = 32'(req.alarm_slot) < NUM_ALARMS;
  assign drop_now = accept && is_set && slot_ok;
  assign out_free = !out_valid || res.ready;

  assign head_due = ent[0].valid && (ent[0].deadline <= tick_count);
  assign next_due = right_of[0].valid && (right_of[0].deadline <= tick_count);
  assign pop_last = (pop_cnt == CNT_W'(MAX_OUT - 1)) || !next_due;
  assign pop_now  = (state == ST_POP) && out_free && head_due;
  assign ins_now  = (state == ST_ACK) && out_free && pend_ins;
  assign emit     = out_free && ((state == ST_ACK) || (state == ST_POP));

  // At most one cell matches; every cell from it rightwards moves left
  assign drop_mask = ~(match - NUM_ALARMS'(1));

  assign req.ready = (state == ST_IDLE);

  genvar i;
  generate
    for (i = 0; i < NUM_ALARMS; i++) begin : g_cell
      if (i == NUM_ALARMS - 1) begin : g_end
        assign right_of[i] = ENTRY_NONE;
      end else begin : g_mid
        assign right_of[i] = ent[i+1];
      end
      if (i == 0) begin : g_head
        assign left_of[i] = ins_ent;
        assign left_gt[i] = 1'b0;
      end else begin : g_body
        assign left_of[i] = ent[i-1];
        assign left_gt[i] = gt[i-1];
      end
      assign ctl[i].shift  = pop_now || (drop_now && drop_mask[i]);
      assign ctl[i].insert = ins_now;

      tkaq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl[i]),
        .prev_gt   (left_gt[i]),
        .prev_ent  (left_of[i]),
        .next_ent  (right_of[i]),
        .ins_ent   (ins_ent),
        .drop_slot (req.alarm_slot),
        .ent       (ent[i]),
        .gt        (gt[i]),
        .match     (match[i])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = is_set ? ST_ACK : ST_POP;
      ST_ACK:  if (out_free) state_next = ST_IDLE;
      ST_POP:  if (out_free && (!head_due || pop_last)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      pop_cnt    <= '0;
      pend_ins   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pop_cnt <= '0;
        if (is_set) begin
          pend_ins <= slot_ok && (req.delay_ticks != '0);
        end else begin
          tick_count <= tick_count + TICK_W'(1);
        end
      end
      if (ins_now) pend_ins <= 1'b0;
      if (pop_now) pop_cnt <= pop_cnt + CNT_W'(1);
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept && is_set) begin
      ins_ent.valid    <= 1'b1;
      ins_ent.slot     <= req.alarm_slot;
      ins_ent.deadline <= tick_count + req.delay_ticks;
    end
    if (emit) begin
      out_tick <= tick_count;
      if (pop_now) begin
        out_fired <= 1'b1;
        out_slot  <= ent[0].slot;
        out_last  <= pop_last;
      end else begin
        out_fired <= 1'b0;
        out_slot  <= '0;
        out_last  <= 1'b1;
      end
    end
  end

  assign res.valid      = out_valid;
  assign res.fired      = out_fired;
  assign res.fired_slot = out_slot;
  assign res.now_tick   = out_tick;
  assign res.last       = out_last;

endmodule
`default_nettype wire

### design/tkaq_cell.sv
// One cell of the sorted alarm chain: holds one queued alarm.
`default_nettype none
module tkaq_cell (
  input  wire                       clk,
  input  wire                       rst,
  input  tkaq_pkg::cell_ctl_t       ctl,
  input  wire                       prev_gt,
  input  tkaq_pkg::entry_t          prev_ent,
  input  tkaq_pkg::entry_t          next_ent,
  input  tkaq_pkg::entry_t          ins_ent,
  input  wire [tkaq_pkg::SLOT_W-1:0] drop_slot,
  output tkaq_pkg::entry_t          ent,
  output logic                      gt,
  output logic                      match
);
  import tkaq_pkg::*;

  // Chain is sorted and packed, so gt is low on a prefix and high after it
  assign gt    = !ent.valid || (ent.deadline > ins_ent.deadline);
  assign match = ent.valid && (ent.slot == drop_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctl.shift) begin
      ent <= next_ent;
    end else if (ctl.insert && gt) begin
      ent <= prev_gt ? prev_ent : ins_ent;
    end
  end

endmodule
`default_nettype wire

### tb/tick_alarm_queue_unit_tb.sv
// Self-checking testbench of the tick alarm queue: directed table, then random traffic.
module tick_alarm_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tkaq_pkg::*;

  localparam int RAND_ITEMS   = 168;
  localparam int CALM_TAIL    = 30;      // final items sent with no idling on either side
  localparam int LONG_HOLD    = 120;     // cycles the result side holds off once
  localparam int DRAIN_CYCLES = 40;
  localparam int N_DIR        = 13;

  typedef struct packed {
    req_kind_t         kind;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] delay;
  } alarm_req_t;

  typedef struct packed {
    logic              fired;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] now;
    logic              last;
  } alarm_res_t;

  typedef struct packed {
    alarm_req_t req;
    bit         typed;   // want holds the only result of this item
    alarm_res_t want;
  } dir_row_t;

  localparam alarm_res_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst;

  tkaq_req_if req_ch();
  tkaq_res_if res_ch();

  tick_alarm_queue_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always #6 clk = ~clk;

  // Deadline wrap, re-arm of a pending slot, equal deadlines, cancels.
  dir_row_t dir_rows [N_DIR] = '{
    '{'{REQ_TICK, 4'd0,  32'd0},          1'b1, '{1'b0, 4'd0, 32'd1, 1'b1}},
    '{'{REQ_SET,  4'd0,  32'd0},          1'b1, '{1'b0, 4'd0, 32'd1, 1'b1}},
    '{'{REQ_SET,  4'd15, 32'hFFFF_FFFF},  1'b1, '{1'b0, 4'd0, 32'd1, 1'b1}},
    '{'{REQ_SET,  4'd3,  32'd2},          1'b0, NO_RES},
    '{'{REQ_SET,  4'd5,  32'd2},          1'b0, NO_RES},
    '{'{REQ_SET,  4'd7,  32'd1},          1'b0, NO_RES},
    '{'{REQ_SET,  4'd5,  32'd1},          1'b0, NO_RES},
    '{'{REQ_TICK, 4'd0,  32'd0},          1'b0, NO_RES},
    '{'{REQ_SET,  4'd9,  32'd0},          1'b0, NO_RES},
    '{'{REQ_SET,  4'd10, 32'h8000_0000},  1'b0, NO_RES},
    '{'{REQ_SET,  4'd10, 32'd0},          1'b0, NO_RES},
    '{'{REQ_TICK, 4'd0,  32'd0},          1'b0, NO_RES},
    '{'{REQ_TICK, 4'd0,  32'd0},          1'b1, '{1'b0, 4'd0, 32'd4, 1'b1}}
  };

  // Mirror of the block: tick counter, per-slot deadline and armed flag, sorted slot list.
  logic [TICK_W-1:0] q_tick;
  logic [TICK_W-1:0] q_deadline [DEF_NUM_ALARMS];
  bit                q_armed    [DEF_NUM_ALARMS];
  logic [SLOT_W-1:0] q_order    [$];
  alarm_res_t        step_out   [$];
  alarm_res_t        owed_results [$];

  int  errors = 0;
  int  n_ticks = 0;
  int  n_sets = 0;
  int  n_fired = 0;
  int  burst = 0;
  int  max_burst = 0;
  bit  calm = 1'b0;
  bit  hold_asked = 1'b0;

  function automatic void unlink_slot(input logic [SLOT_W-1:0] s);
    int i;
    if (!q_armed[s]) return;
    for (i = 0; i < q_order.size(); i++) begin
      if (q_order[i] == s) begin
        q_order.delete(i);
        break;
      end
    end
    q_armed[s] = 1'b0;
  endfunction

  function automatic void push_result(input logic f, input logic [SLOT_W-1:0] s,
                                      input logic l);
    alarm_res_t r;
    r.fired = f;
    r.slot  = s;
    r.now   = q_tick;
    r.last  = l;
    step_out.push_back(r);
  endfunction

  // Works out the results of one item into step_out and updates the mirror.
  function automatic void advance_alarm_queue(input alarm_req_t r);
    logic [TICK_W-1:0] dl;
    logic [SLOT_W-1:0] head;
    alarm_res_t        tail;
    int                pos;
    int                n;
    step_out.delete();
    if (r.kind == REQ_SET) begin
      unlink_slot(r.slot);
      if (r.delay != 0) begin
        dl  = q_tick + r.delay;
        pos = 0;
        while (pos < q_order.size() && q_deadline[q_order[pos]] <= dl) pos++;
        q_order.insert(pos, r.slot);
        q_deadline[r.slot] = dl;
        q_armed[r.slot]    = 1'b1;
      end
      push_result(1'b0, '0, 1'b1);
    end else begin
      q_tick = q_tick + 1;
      n = 0;
      while (n < MAX_OUT && q_order.size() > 0 && q_deadline[q_order[0]] <= q_tick) begin
        head = q_order[0];
        unlink_slot(head);
        push_result(1'b1, head, 1'b0);
        n++;
      end
      if (n == 0) begin
        push_result(1'b0, '0, 1'b1);
      end else begin
        tail = step_out.pop_back();
        tail.last = 1'b1;
        step_out.push_back(tail);
      end
    end
  endfunction

  task automatic send_request(input alarm_req_t r, input bit typed, input alarm_res_t want);
    int i;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.kind;
    req_ch.alarm_slot  <= r.slot;
    req_ch.delay_ticks <= r.delay;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    advance_alarm_queue(r);
    if (typed) begin
      owed_results.push_back(want);
    end else begin
      for (i = 0; i < step_out.size(); i++) owed_results.push_back(step_out[i]);
    end
    if (r.kind == REQ_TICK) n_ticks++;
    else n_sets++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    alarm_req_t plan [$];
    alarm_req_t it;
    int         i;
    int         s;
    int         base;
    logic [SLOT_W-1:0] mask;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_TICK;
    req_ch.alarm_slot  = '0;
    req_ch.delay_ticks = '0;
    rst    = 1'b1;
    q_tick = '0;
    for (i = 0; i < DEF_NUM_ALARMS; i++) begin
      q_armed[i]    = 1'b0;
      q_deadline[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < N_DIR; i++) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // Random plan: mostly single sets, cancels and ticks; now and then every slot
    // armed close together so that the ticks after them fire the whole queue.
    while (plan.size() < RAND_ITEMS) begin
      if (plan.size() == 0 || $urandom_range(0, 9) == 0) begin
        base = $urandom_range(1, 3);
        mask = SLOT_W'($urandom_range(0, DEF_NUM_ALARMS - 1));
        for (s = 0; s < DEF_NUM_ALARMS; s++) begin
          it.kind  = REQ_SET;
          it.slot  = s[SLOT_W-1:0] ^ mask;
          it.delay = base + $urandom_range(0, 1);
          plan.push_back(it);
        end
        for (s = 0; s < 5; s++) begin
          it = '0;
          it.kind = REQ_TICK;
          it.slot = SLOT_W'($urandom_range(0, DEF_NUM_ALARMS - 1));
          plan.push_back(it);
        end
      end else begin
        it.kind  = REQ_SET;
        it.slot  = SLOT_W'($urandom_range(0, DEF_NUM_ALARMS - 1));
        it.delay = $urandom_range(1, 6);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            it.kind  = REQ_TICK;
            it.delay = $urandom();
          end
          7: it.delay = '0;
          8: it.delay = $urandom();
          9: it.delay = 32'hFFFF_FFFF - $urandom_range(0, 2);  // lands just below now
          default: ;
        endcase
        plan.push_back(it);
      end
    end

    hold_asked = 1'b1;  // first full queue meets a long stall on the result side
    for (i = 0; i < plan.size(); i++) begin
      calm = (i >= plan.size() - CALM_TAIL);
      send_request(plan[i], 1'b0, NO_RES);
    end
    req_ch.valid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d ticks and %0d set or cancel items; %0d alarms fired, up to %0d on one tick.",
             n_ticks, n_sets, n_fired, max_burst);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : result_side
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_asked) begin
        hold_asked = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  function automatic void compare_field(input string name, input logic [TICK_W-1:0] want,
                                        input logic [TICK_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    alarm_res_t got;
    alarm_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.fired = res_ch.fired;
      got.slot  = res_ch.fired_slot;
      got.now   = res_ch.now_tick;
      got.last  = res_ch.last;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, fired %0b slot %0d now %0h last %0b",
                 $realtime, got.fired, got.slot, got.now, got.last);
      end else begin
        want = owed_results.pop_front();
        compare_field("fired", TICK_W'(want.fired), TICK_W'(got.fired));
        compare_field("fired_slot", TICK_W'(want.slot), TICK_W'(got.slot));
        compare_field("now_tick", want.now, got.now);
        compare_field("last", TICK_W'(want.last), TICK_W'(got.last));
      end
      if (got.fired === 1'b1) begin
        n_fired++;
        burst++;
      end
      if (got.last === 1'b1) begin
        if (burst > max_burst) max_burst = burst;
        burst = 0;
      end
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timed out with %0d results outstanding", owed_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
design/tkaq_pkg.sv
design/tkaq_if.sv
design/tkaq_cell.sv
design/tick_alarm_queue_unit.sv
tb/tick_alarm_queue_unit_tb.sv
